FILE: sv/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants, types and helper functions of the textured column
// renderer.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int SCREEN_ROWS    = 25;
  localparam int TEXTURE_HEIGHT = 32;
  localparam int COLOUR_ENTRIES = 16;

  localparam int SCREEN_COLS  = 40;
  localparam int TEX_COLS     = 32;
  localparam int TEX_SIZE     = TEX_COLS * TEXTURE_HEIGHT;
  localparam int TEX_AW       = $clog2(2 * TEX_SIZE);
  localparam int COL_AW       = $clog2(2 * COLOUR_ENTRIES);
  localparam int CIDX_W       = $clog2(COLOUR_ENTRIES);
  localparam int ROW_W        = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int ACC_W        = 16;
  localparam int FRAC_BITS    = 10;
  localparam int ADDR_W       = 16;
  localparam int TEX_LOAD_W   = 10;
  localparam int TEX_LOAD_SEL = 10;
  localparam int COL_LOAD_W   = 4;
  localparam int COL_LOAD_SEL = 4;
  localparam int CSUM_W       = 5;

  localparam logic [7:0] CH_BLANK     = 8'd32;
  localparam logic [7:0] CH_SOLID     = 8'd160;
  localparam logic [3:0] FLOOR_COLOUR = 4'd9;
  localparam logic [3:0] BLANK_COLOUR = 4'd0;
  localparam logic [7:0] KIND_FIRST   = 8'd1;
  localparam int         SIDE_BONUS   = 2;

  localparam int ITEM_W   = 99;
  localparam int S_DATA_W = 104;
  localparam int RESULT_W = 44;
  localparam int M_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_DRAW     = 2'd0,
    CMD_LOAD_TEX = 2'd1,
    CMD_LOAD_COL = 2'd2,
    CMD_RSVD     = 2'd3
  } tcr_cmd_e;

  // last field in the lowest bits
  typedef struct packed {
    logic [3:0]  load_data;
    logic [10:0] load_index;
    logic [15:0] colour_base;
    logic [15:0] char_base;
    logic [7:0]  wall_kind;
    logic [15:0] row_step;
    logic [4:0]  texture_column;
    logic        hit_side;
    logic [7:0]  wall_end;
    logic [7:0]  wall_start;
    logic [5:0]  column;
  } tcr_item_t;

  typedef struct packed {
    logic [3:0]        colour_value;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] colour_address;
    logic [ADDR_W-1:0] char_address;
  } tcr_result_t;

  typedef struct packed {
    logic             capture;
    logic             tex_we;
    logic             col_we;
    logic             issue;
    logic             last;
    logic [ROW_W-1:0] row;
  } tcr_cmd_t;

  typedef struct packed {
    logic advance;
    logic empty;
  } tcr_status_t;

  function automatic logic [TEX_AW-1:0] tex_wrap(logic [TEX_AW-1:0] v);
    logic [TEX_AW-1:0] r;
    r = v;
    if (int'(r) >= TEX_SIZE) r = r - TEX_AW'(TEX_SIZE);
    return r;
  endfunction

  function automatic logic [TEX_LOAD_W-1:0] load_wrap(logic [TEX_LOAD_W-1:0] v);
    logic [TEX_LOAD_W-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= TEX_SIZE) r = r - TEX_LOAD_W'(TEX_SIZE);
    end
    return r;
  endfunction

  function automatic logic [CIDX_W-1:0] col_wrap(logic [CSUM_W-1:0] v);
    logic [CSUM_W-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= COLOUR_ENTRIES) r = r - CSUM_W'(COLOUR_ENTRIES);
    end
    return CIDX_W'(r);
  endfunction

endpackage

FILE: sv/tcr_ctrl.sv
// ----------------------------------------------------------------------------
// tcr_ctrl
// Command decode and row sequencer: accepts requests, drives the datapath
// with write strobes and one row issue per unstalled cycle of a draw.
// ----------------------------------------------------------------------------
module tcr_ctrl import tcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic [1:0]  s_user_i,
  output logic        s_ready_o,
  input  tcr_status_t status_i,
  output tcr_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;
  logic             last_row;
  tcr_cmd_e         cmd;

  assign cmd       = tcr_cmd_e'(s_user_i);
  assign s_ready_o = (state_q == ST_IDLE) && status_i.empty;
  assign accept    = s_valid_i && s_ready_o;
  assign last_row  = (row_q == ROW_W'(SCREEN_ROWS - 1));

  always_comb begin
    cmd_o.capture = accept && (cmd == CMD_DRAW);
    cmd_o.tex_we  = accept && (cmd == CMD_LOAD_TEX);
    cmd_o.col_we  = accept && (cmd == CMD_LOAD_COL);
    cmd_o.issue   = (state_q == ST_RUN) && status_i.advance;
    cmd_o.last    = last_row;
    cmd_o.row     = row_q;
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cmd == CMD_DRAW)) begin
          state_d = ST_RUN;
          row_d   = '0;
        end
      end
      ST_RUN: begin
        if (status_i.advance) begin
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

endmodule

FILE: sv/tcr_datapath.sv
// ----------------------------------------------------------------------------
// tcr_datapath
// Texture and colour stores, texture row accumulator and a three-stage row
// pipe: texel read, colour read, output register. The whole pipe stalls
// while the output register is held.
// ----------------------------------------------------------------------------
module tcr_datapath import tcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tcr_item_t   item_i,
  input  tcr_cmd_t    cmd_i,
  output tcr_status_t status_o,
  input  logic        m_ready_i,
  output logic        m_valid_o,
  output logic        m_last_o,
  output tcr_result_t result_o
);

  logic [3:0] tex_mem [2*TEX_SIZE];
  logic [3:0] col_mem [2*COLOUR_ENTRIES];

  // captured draw request
  logic [7:0]        start_q, end_q;
  logic              side_q, sel_q;
  logic [4:0]        tcol_q;
  logic [ACC_W-1:0]  step_q;
  logic [ADDR_W-1:0] cbase_q, kbase_q;

  logic [ACC_W-1:0]  acc_q;
  logic [ADDR_W-1:0] off_q;

  logic              v1_q, v2_q, out_valid_q;
  logic              advance;

  logic [7:0]        row8;
  logic              wall0, floor0;
  logic [TEX_AW-1:0] tidx, tex_raddr, tex_waddr;
  logic [TEX_LOAD_W-1:0] tex_ent;

  logic [ADDR_W-1:0] s1_ca_q, s1_ka_q, s2_ca_q, s2_ka_q;
  logic              s1_wall_q, s1_floor_q, s1_last_q;
  logic              s2_wall_q, s2_floor_q, s2_last_q;
  logic [3:0]        tex_rd_q, col_rd_q;

  logic [CSUM_W-1:0] csum;
  logic [CIDX_W-1:0] cidx, cent;
  logic [COL_AW-1:0] col_raddr, col_waddr;

  logic              last_q;
  tcr_result_t       result_q;

  assign advance         = !out_valid_q || m_ready_i;
  assign status_o.advance = advance;
  assign status_o.empty   = !v1_q && !v2_q;
  assign m_valid_o       = out_valid_q;
  assign m_last_o        = last_q;
  assign result_o        = result_q;

  // stage 0: row classification and texel address
  always_comb begin
    row8      = 8'(cmd_i.row);
    wall0     = (row8 >= start_q) && (row8 < end_q);
    floor0    = (row8 >= end_q);
    tidx      = tex_wrap(TEX_AW'(tcol_q) * TEX_AW'(TEXTURE_HEIGHT)
                         + TEX_AW'(acc_q[ACC_W-1:FRAC_BITS]));
    tex_raddr = sel_q ? tidx + TEX_AW'(TEX_SIZE) : tidx;
    tex_ent   = load_wrap(item_i.load_index[TEX_LOAD_W-1:0]);
    tex_waddr = item_i.load_index[TEX_LOAD_SEL] ?
                TEX_AW'(tex_ent) + TEX_AW'(TEX_SIZE) : TEX_AW'(tex_ent);
  end

  // stage 1: colour index
  always_comb begin
    csum      = CSUM_W'(tex_rd_q) + (side_q ? CSUM_W'(0) : CSUM_W'(SIDE_BONUS));
    cidx      = col_wrap(csum);
    col_raddr = sel_q ? COL_AW'(cidx) + COL_AW'(COLOUR_ENTRIES) : COL_AW'(cidx);
    cent      = col_wrap(CSUM_W'(item_i.load_index[COL_LOAD_W-1:0]));
    col_waddr = item_i.load_index[COL_LOAD_SEL] ?
                COL_AW'(cent) + COL_AW'(COLOUR_ENTRIES) : COL_AW'(cent);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tex_we) begin
      tex_mem[tex_waddr] <= item_i.load_data;
    end
    if (advance) begin
      tex_rd_q <= tex_mem[tex_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_we) begin
      col_mem[col_waddr] <= item_i.load_data;
    end
    if (advance) begin
      col_rd_q <= col_mem[col_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      off_q       <= '0;
    end else begin
      if (advance) begin
        v1_q        <= cmd_i.issue;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
      if (cmd_i.capture) begin
        acc_q <= '0;
        off_q <= ADDR_W'(item_i.column);
      end else if (cmd_i.issue) begin
        off_q <= off_q + ADDR_W'(SCREEN_COLS);
        if (wall0) begin
          acc_q <= acc_q + step_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      start_q <= item_i.wall_start;
      end_q   <= item_i.wall_end;
      side_q  <= item_i.hit_side;
      sel_q   <= (item_i.wall_kind != KIND_FIRST);
      tcol_q  <= item_i.texture_column;
      step_q  <= item_i.row_step;
      cbase_q <= item_i.char_base;
      kbase_q <= item_i.colour_base;
    end
    if (advance) begin
      s1_ca_q    <= cbase_q + off_q;
      s1_ka_q    <= kbase_q + off_q;
      s1_wall_q  <= wall0;
      s1_floor_q <= floor0;
      s1_last_q  <= cmd_i.last;
      s2_ca_q    <= s1_ca_q;
      s2_ka_q    <= s1_ka_q;
      s2_wall_q  <= s1_wall_q;
      s2_floor_q <= s1_floor_q;
      s2_last_q  <= s1_last_q;
      result_q.char_address   <= s2_ca_q;
      result_q.colour_address <= s2_ka_q;
      result_q.char_code      <= (s2_wall_q || s2_floor_q) ? CH_SOLID : CH_BLANK;
      result_q.colour_value   <= s2_wall_q  ? col_rd_q :
                                 s2_floor_q ? FLOOR_COLOUR : BLANK_COLOUR;
      last_q <= s2_last_q;
    end
  end

endmodule

FILE: sv/textured_column_renderer.sv
// ----------------------------------------------------------------------------
// textured_column_renderer
// Renders one textured wall column of a character screen per draw request.
// ----------------------------------------------------------------------------
// Load requests (texture entry, colour table entry) give no result. A draw
// request gives SCREEN_ROWS results, top row first, one per cycle while the
// output is not stalled, as the row sequencer steps through the column; each
// result passes through texel read, colour read and output register. The
// next request is taken once no row is left in the pipe but the output
// register. Output stalls hold the whole row pipe.
module textured_column_renderer import tcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // column, wall_start, wall_end, hit_side, texture_column, row_step,
  // wall_kind, char_base, colour_base, load_index, load_data
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // command
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // char_address, colour_address, char_code, colour_value
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  tcr_item_t   item;
  tcr_cmd_t    cmd;
  tcr_status_t status;
  tcr_result_t result;

  assign item           = tcr_item_t'(s_axis_tdata_i[ITEM_W-1:0]);
  assign m_axis_tdata_o = {(M_DATA_W - RESULT_W)'(0), result};

  tcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_user_i  (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcr_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .cmd_i     (cmd),
    .status_o  (status),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_last_o  (m_axis_tlast_o),
    .result_o  (result)
  );

endmodule

FILE: sv/tcr_checker.sv
// ----------------------------------------------------------------------------
// tcr_checker
// Port-level checks of the textured column renderer, bound to the top level.
// ----------------------------------------------------------------------------
module tcr_checker import tcr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [1:0]          s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [M_DATA_W-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  logic [7:0] code;
  logic [3:0] colour;

  assign code   = m_axis_tdata_o[39:32];
  assign colour = m_axis_tdata_o[43:40];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == 2'(CMD_DRAW)) |=>
      !s_axis_tready_o)
    else $error("request taken during a draw");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (code == CH_BLANK) || (code == CH_SOLID))
    else $error("bad character code");

  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (code == CH_BLANK) |-> colour == BLANK_COLOUR)
    else $error("blank cell with colour");

endmodule

bind textured_column_renderer tcr_checker u_checker (.*);
